FILE: src/lofc_pkg.sv
// Shared types and constants for the lamp occupancy and fade controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package lofc_pkg;

    localparam int HOURS     = 24;
    localparam int HOUR_W    = 5;
    localparam int LEVEL_W   = 7;
    localparam int RUN_W     = 16;
    localparam int CNT_W     = 32;
    localparam int TICK_W    = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 104;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MANUAL_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MANUAL_LEVEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_LUX_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ABSENCE_TICKS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STANDBY_LEVEL  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_LEVEL     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP      = 3'd7;

    // register reset values
    localparam logic [RUN_W-1:0]   RST_DARK_LUX_LIMIT = 16'd200;
    localparam logic [RUN_W-1:0]   RST_PRESENCE_TICKS = 16'd100;
    localparam logic [RUN_W-1:0]   RST_ABSENCE_TICKS  = 16'd250;
    localparam logic [LEVEL_W-1:0] RST_STANDBY_LEVEL  = 7'd20;
    localparam logic [LEVEL_W-1:0] RST_FULL_LEVEL     = 7'd100;
    localparam logic [LEVEL_W-1:0] RST_FADE_STEP      = 7'd2;

    typedef struct packed {
        logic               manual_mode;
        logic [LEVEL_W-1:0] manual_level;
        logic [RUN_W-1:0]   dark_lux_limit;
        logic [RUN_W-1:0]   presence_ticks;
        logic [RUN_W-1:0]   absence_ticks;
        logic [LEVEL_W-1:0] standby_level;
        logic [LEVEL_W-1:0] full_level;
        logic [LEVEL_W-1:0] fade_step;
    } lofc_cfg_t;

    // per-request control result, before the lit-seconds lookup
    typedef struct packed {
        logic [LEVEL_W-1:0] brightness;
        logic [LEVEL_W-1:0] target_level;
        logic               dark;
        logic               night;
        logic               occupied;
        logic [RUN_W-1:0]   still_count;
        logic               turned_on;
        logic               turned_off;
        logic [CNT_W-1:0]   on_events;
        logic               sec_done;
    } lofc_ctl_t;

endpackage

`default_nettype wire

FILE: src/lofc_ctrl.sv
// Occupancy qualification, target selection, fade and on-event counting.
// Holds the per-tick state registers; depends on lofc_pkg.
`default_nettype none

module lofc_ctrl
    import lofc_pkg::*;
#(
    parameter int TICKS_PER_SECOND = 50,
    parameter int NIGHT_START      = 19,
    parameter int NIGHT_END        = 6
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic              motion,
    input  wire logic [RUN_W-1:0]  lux,
    input  wire logic [HOUR_W-1:0] hour_now,
    input  wire lofc_cfg_t         cfg,
    output lofc_ctl_t              res
);

    localparam logic [HOUR_W-1:0] NSTART = HOUR_W'(NIGHT_START);
    localparam logic [HOUR_W-1:0] NEND   = HOUR_W'(NIGHT_END);
    localparam logic [TICK_W-1:0] TPS    = TICK_W'(TICKS_PER_SECOND);

    logic [LEVEL_W-1:0] level_reg,      level_next;
    logic [RUN_W-1:0]   motion_run_reg, motion_run_next;
    logic [RUN_W-1:0]   still_run_reg,  still_run_next;
    logic               present_reg,    present_next;
    logic               was_lit_reg,    was_lit_next;
    logic [TICK_W-1:0]  sec_ticks_reg,  sec_ticks_next;
    logic [CNT_W-1:0]   on_total_reg,   on_total_next;

    logic               night;
    logic               dark;
    logic [LEVEL_W-1:0] target;
    logic [LEVEL_W:0]   up_sum;
    logic               lit;
    logic               on_edge;
    logic               off_edge;
    logic [TICK_W-1:0]  tick_inc;
    logic               sec_done;

    always_comb
    begin
        night = (hour_now >= NSTART) || (hour_now < NEND);
        dark  = night && (lux < cfg.dark_lux_limit);

        motion_run_next = motion_run_reg;
        still_run_next  = still_run_reg;
        present_next    = present_reg;
        if (cfg.manual_mode)
        begin
            target = cfg.manual_level;
        end
        else if (!dark)
        begin
            target          = '0;
            present_next    = 1'b0;
            motion_run_next = '0;
            still_run_next  = '0;
        end
        else
        begin
            if (motion)
            begin
                motion_run_next = (&motion_run_reg) ? motion_run_reg : motion_run_reg + 1'b1;
                still_run_next  = '0;
                if (motion_run_next >= cfg.presence_ticks)
                    present_next = 1'b1;
            end
            else
            begin
                still_run_next  = (&still_run_reg) ? still_run_reg : still_run_reg + 1'b1;
                motion_run_next = '0;
                if (still_run_next >= cfg.absence_ticks)
                    present_next = 1'b0;
            end
            target = present_next ? cfg.full_level : cfg.standby_level;
        end

        // slew by one step, clamp to 0..100
        up_sum = {1'b0, level_reg} + {1'b0, cfg.fade_step};
        if (level_reg < target)
            level_next = (up_sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : up_sum[LEVEL_W-1:0];
        else if (level_reg > target)
            level_next = (level_reg < cfg.fade_step) ? '0 : level_reg - cfg.fade_step;
        else
            level_next = level_reg;

        lit           = (level_next != '0);
        on_edge       = lit && !was_lit_reg;
        off_edge      = !lit && was_lit_reg;
        was_lit_next  = lit;
        on_total_next = (on_edge && !(&on_total_reg)) ? on_total_reg + 1'b1 : on_total_reg;

        tick_inc = sec_ticks_reg + 1'b1;
        sec_done = 1'b0;
        if (lit)
        begin
            if (tick_inc >= TPS)
            begin
                sec_ticks_next = '0;
                sec_done       = 1'b1;
            end
            else
            begin
                sec_ticks_next = tick_inc;
            end
        end
        else
        begin
            sec_ticks_next = '0;
        end

        res.brightness   = level_next;
        res.target_level = target;
        res.dark         = dark;
        res.night        = night;
        res.occupied     = present_next;
        res.still_count  = still_run_next;
        res.turned_on    = on_edge;
        res.turned_off   = off_edge;
        res.on_events    = on_total_next;
        res.sec_done     = sec_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg      <= '0;
            motion_run_reg <= '0;
            still_run_reg  <= '0;
            present_reg    <= 1'b0;
            was_lit_reg    <= 1'b0;
            sec_ticks_reg  <= '0;
            on_total_reg   <= '0;
        end
        else if (step)
        begin
            level_reg      <= level_next;
            motion_run_reg <= motion_run_next;
            still_run_reg  <= still_run_next;
            present_reg    <= present_next;
            was_lit_reg    <= was_lit_next;
            sec_ticks_reg  <= sec_ticks_next;
            on_total_reg   <= on_total_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/lofc_lit_store.sv
// Lit-seconds per hour store: 24 x 32 memory with registered reads,
// valid bits for reset, and one-deep write forwarding. Depends on lofc_pkg.
`default_nettype none

module lofc_lit_store
    import lofc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,      // request moves into the read stage
    input  wire logic [HOUR_W-1:0] rd_hour,
    input  wire logic [HOUR_W-1:0] rd_rhour,
    input  wire logic              rd_incr,
    input  wire logic              adv,        // request leaves the read stage
    output logic [CNT_W-1:0]       read_seconds
);

    logic [CNT_W-1:0]  mem [HOURS];
    logic [HOURS-1:0]  vld_reg;

    logic              h_ok,   r_ok;
    logic [HOUR_W-1:0] h_idx,  r_idx;

    logic [HOUR_W-1:0] hour_reg;
    logic [HOUR_W-1:0] rhour_reg;
    logic              incr_reg;
    logic              h_ok_reg;
    logic              r_ok_reg;
    logic [CNT_W-1:0]  rd_h_reg;
    logic [CNT_W-1:0]  rd_r_reg;
    logic              vh_reg;
    logic              vr_reg;

    logic              fwd_vld_reg;
    logic [HOUR_W-1:0] fwd_addr_reg;
    logic [CNT_W-1:0]  fwd_data_reg;

    logic [CNT_W-1:0]  cur_h, cur_r, new_h;
    logic              wr_en;

    assign h_ok  = (rd_hour < HOUR_W'(HOURS));
    assign r_ok  = (rd_rhour < HOUR_W'(HOURS));
    assign h_idx = h_ok ? rd_hour : '0;
    assign r_idx = r_ok ? rd_rhour : '0;

    always_comb
    begin
        // a write at the edge this request was read is not yet in rd_*_reg
        if (fwd_vld_reg && (fwd_addr_reg == hour_reg))
            cur_h = fwd_data_reg;
        else
            cur_h = vh_reg ? rd_h_reg : '0;

        if (fwd_vld_reg && (fwd_addr_reg == rhour_reg))
            cur_r = fwd_data_reg;
        else
            cur_r = vr_reg ? rd_r_reg : '0;

        new_h = (&cur_h) ? cur_h : cur_h + 1'b1;
        wr_en = adv && incr_reg && h_ok_reg;

        if (!r_ok_reg)
            read_seconds = '0;
        else if (incr_reg && h_ok_reg && (rhour_reg == hour_reg))
            read_seconds = new_h;
        else
            read_seconds = cur_r;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_h_reg  <= mem[h_idx];
            rd_r_reg  <= mem[r_idx];
            hour_reg  <= rd_hour;
            rhour_reg <= rd_rhour;
        end
        if (wr_en)
            mem[hour_reg] <= new_h;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            incr_reg     <= 1'b0;
            h_ok_reg     <= 1'b0;
            r_ok_reg     <= 1'b0;
            vh_reg       <= 1'b0;
            vr_reg       <= 1'b0;
            fwd_vld_reg  <= 1'b0;
            fwd_addr_reg <= '0;
            fwd_data_reg <= '0;
        end
        else
        begin
            if (rd_en)
            begin
                incr_reg     <= rd_incr;
                h_ok_reg     <= h_ok;
                r_ok_reg     <= r_ok;
                vh_reg       <= h_ok && vld_reg[h_idx];
                vr_reg       <= r_ok && vld_reg[r_idx];
                fwd_vld_reg  <= wr_en;
                fwd_addr_reg <= hour_reg;
                fwd_data_reg <= new_h;
            end
            if (wr_en)
                vld_reg[hour_reg] <= 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: src/lamp_occupancy_fade_controller.sv
// Top level: config registers, input/read/output pipeline and stream ports.
// Depends on lofc_pkg, lofc_ctrl, lofc_lit_store.
//
//  port group   dir  width  contents
//  s_axis       in   32     one control tick request
//  m_axis       out  104    one status result per request
//  cfg          in   3+16   register write, no read-back
//
// Three registered stages: input, store read, output. One request per cycle
// sustained while the output is not stalled. The store read and its one-deep
// forward set the middle stage. All stages advance together when the output
// register is empty or taken; s_tready follows it. Reset clears the config,
// control and valid state, and the 24 hourly totals by per-entry valid bits.
`default_nettype none

module lamp_occupancy_fade_controller
    import lofc_pkg::*;
#(
    parameter int TICKS_PER_SECOND = 50,
    parameter int NIGHT_START      = 19,
    parameter int NIGHT_END        = 6
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // motion[0], lux[16:1], hour_now[21:17], read_hour[26:22], zero [31:27]
    input  wire logic [IN_W-1:0]      s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // brightness[6:0], target_level[13:7], dark[14], night[15], occupied[16],
    // still_count[32:17], turned_on[33], turned_off[34], on_events[66:35],
    // read_seconds[98:67], zero [103:99]
    output logic [OUT_W-1:0]          m_tdata,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    lofc_cfg_t          cfg_reg;
    logic               en;

    logic               s1_vld_reg;
    logic               s1_motion_reg;
    logic [RUN_W-1:0]   s1_lux_reg;
    logic [HOUR_W-1:0]  s1_hour_reg;
    logic [HOUR_W-1:0]  s1_rhour_reg;

    logic               s2_vld_reg;
    lofc_ctl_t          s2_reg;

    logic               out_vld_reg;
    lofc_ctl_t          out_reg;
    logic [CNT_W-1:0]   out_rsec_reg;

    lofc_ctl_t          ctl_res;
    logic [CNT_W-1:0]   read_seconds;
    logic               step;
    logic               adv;

    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;
    assign step     = en && s1_vld_reg;
    assign adv      = en && s2_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.manual_mode    <= 1'b0;
            cfg_reg.manual_level   <= '0;
            cfg_reg.dark_lux_limit <= RST_DARK_LUX_LIMIT;
            cfg_reg.presence_ticks <= RST_PRESENCE_TICKS;
            cfg_reg.absence_ticks  <= RST_ABSENCE_TICKS;
            cfg_reg.standby_level  <= RST_STANDBY_LEVEL;
            cfg_reg.full_level     <= RST_FULL_LEVEL;
            cfg_reg.fade_step      <= RST_FADE_STEP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MANUAL_MODE:    cfg_reg.manual_mode    <= cfg_data[0];
                REG_MANUAL_LEVEL:   cfg_reg.manual_level   <= cfg_data[LEVEL_W-1:0];
                REG_DARK_LUX_LIMIT: cfg_reg.dark_lux_limit <= cfg_data[RUN_W-1:0];
                REG_PRESENCE_TICKS: cfg_reg.presence_ticks <= cfg_data[RUN_W-1:0];
                REG_ABSENCE_TICKS:  cfg_reg.absence_ticks  <= cfg_data[RUN_W-1:0];
                REG_STANDBY_LEVEL:  cfg_reg.standby_level  <= cfg_data[LEVEL_W-1:0];
                REG_FULL_LEVEL:     cfg_reg.full_level     <= cfg_data[LEVEL_W-1:0];
                REG_FADE_STEP:      cfg_reg.fade_step      <= cfg_data[LEVEL_W-1:0];
            endcase
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= s_tvalid;
            s2_vld_reg  <= s1_vld_reg;
            out_vld_reg <= s2_vld_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en && s_tvalid)
        begin
            s1_motion_reg <= s_tdata[0];
            s1_lux_reg    <= s_tdata[16:1];
            s1_hour_reg   <= s_tdata[21:17];
            s1_rhour_reg  <= s_tdata[26:22];
        end
        if (step)
            s2_reg <= ctl_res;
        if (adv)
        begin
            out_reg      <= s2_reg;
            out_rsec_reg <= read_seconds;
        end
    end

    lofc_ctrl #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .NIGHT_START      (NIGHT_START),
        .NIGHT_END        (NIGHT_END)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .motion   (s1_motion_reg),
        .lux      (s1_lux_reg),
        .hour_now (s1_hour_reg),
        .cfg      (cfg_reg),
        .res      (ctl_res)
    );

    lofc_lit_store u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .rd_en        (step),
        .rd_hour      (s1_hour_reg),
        .rd_rhour     (s1_rhour_reg),
        .rd_incr      (ctl_res.sec_done),
        .adv          (adv),
        .read_seconds (read_seconds)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'b0, out_rsec_reg, out_reg.on_events, out_reg.turned_off,
                       out_reg.turned_on, out_reg.still_count, out_reg.occupied,
                       out_reg.night, out_reg.dark, out_reg.target_level,
                       out_reg.brightness};

endmodule

`default_nettype wire

FILE: src/lofc_checker.sv
// Port-level checks for the lamp occupancy and fade controller, bound to the top.
// Depends on lofc_pkg and lamp_occupancy_fade_controller.
`default_nettype none

module lofc_checker
    import lofc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             m_tvalid,
    input  wire logic             m_tready,
    input  wire logic [OUT_W-1:0] m_tdata
);

    // stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[6:0] <= LEVEL_MAX))
        else $error("brightness above full scale");

    a_edges: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[33] && m_tdata[34]))
        else $error("on and off edge together");

    a_edge_lvl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tdata[33] || (m_tdata[6:0] != '0))
                  && (!m_tdata[34] || (m_tdata[6:0] == '0)))
        else $error("edge flag disagrees with brightness");

    a_dark: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[14] |-> m_tdata[15])
        else $error("dark outside night hours");

endmodule

bind lamp_occupancy_fade_controller lofc_checker u_lofc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
